// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge while reset is released.
`define CRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define CRB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/crb_pkg.sv =====
// Package with shared widths, register indexes and defaults of the ribbon quad block.
package crb_pkg;
  localparam int unsigned MaxQuadsDef = 64;

  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 56;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned RAD_W  = 70;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned QUO_W  = 56;

  localparam logic [1:0] REG_EYE_X      = 2'd0;
  localparam logic [1:0] REG_EYE_Y      = 2'd1;
  localparam logic [1:0] REG_EYE_Z      = 2'd2;
  localparam logic [1:0] REG_HALF_WIDTH = 2'd3;

  localparam logic [15:0] HALF_WIDTH_RST = 16'd1536;
endpackage

// ===== rtl/core/camera_facing_ribbon_quads.sv =====
// Top level of the camera-facing ribbon quad extruder with its sequencer.
// A point that starts a path, follows no held point or exceeds the quad limit is accepted
// and yields no beat. A point that gives a zero side runs the six cross-product passes of
// the bit-serial multiplier and then yields no beat. Any other point runs twelve multiplier
// passes, a square root and a divide, then sends four corner beats. The multiplier, root
// and divider iterate one bit per cycle. No new point is taken until the last corner beat
// has been delivered.
module camera_facing_ribbon_quads import crb_pkg::*; #(
  parameter int unsigned MAX_QUADS = MaxQuadsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // point_x, point_y, point_z
  input  logic        s_axis_tuser,   // path_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // vertex_x, vertex_y, vertex_z
  output logic [1:0]  m_axis_tuser,   // corner
  output logic        m_axis_tlast    // quad_last
);
  localparam int unsigned QW = $clog2(MAX_QUADS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MGO  = 4'd1;
  localparam logic [3:0] ST_MWT  = 4'd2;
  localparam logic [3:0] ST_SGO  = 4'd3;
  localparam logic [3:0] ST_SWT  = 4'd4;
  localparam logic [3:0] ST_DGO  = 4'd5;
  localparam logic [3:0] ST_DWT  = 4'd6;
  localparam logic [3:0] ST_LOAD = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  localparam logic [3:0] OP_DY_TZ      = 4'd0;
  localparam logic [3:0] OP_DZ_TY      = 4'd1;
  localparam logic [3:0] OP_DZ_TX      = 4'd2;
  localparam logic [3:0] OP_DX_TZ      = 4'd3;
  localparam logic [3:0] OP_DX_TY      = 4'd4;
  localparam logic [3:0] OP_LAST_CROSS = 4'd5;
  localparam logic [3:0] OP_SQ_X       = 4'd6;
  localparam logic [3:0] OP_SQ_Y       = 4'd7;
  localparam logic [3:0] OP_LAST_SQ    = 4'd8;
  localparam logic [3:0] OP_FIRST_OFF  = 4'd9;
  localparam logic [3:0] OP_OFF_Y      = 4'd10;
  localparam logic [3:0] OP_LAST_OFF   = 4'd11;

  localparam logic [1:0] CORNER_B_MINUS = 2'd3;

  function automatic logic [16:0] abs17(logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [33:0] abs35(logic signed [34:0] v);
    logic [34:0] m;
    m = v[34] ? 35'(-v) : 35'(v);
    return m[33:0];
  endfunction

  function automatic logic [15:0] place(logic signed [15:0] p, logic signed [26:0] off,
                                        logic neg);
    logic signed [32:0] pe, oe, sm;
    logic [32:0]        mg;
    logic signed [17:0] tv;
    pe = {p[15], p, 16'h0000};
    oe = {{6{off[26]}}, off};
    sm = neg ? pe - oe : pe + oe;
    mg = sm[32] ? 33'(-sm) : 33'(sm);
    tv = sm[32] ? -$signed({1'b0, mg[32:16]}) : $signed({1'b0, mg[32:16]});
    if (tv > 18'sd32767) begin
      return 16'h7fff;
    end else if (tv < -18'sd32768) begin
      return 16'h8000;
    end
    return tv[15:0];
  endfunction

  logic [3:0]         state_q, state_d;
  logic [3:0]         op_q;
  logic signed [15:0] eye_x_q, eye_y_q, eye_z_q;
  logic [15:0]        hw_q;
  logic signed [15:0] prev_x_q, prev_y_q, prev_z_q;
  logic signed [15:0] a_x_q, a_y_q, a_z_q;
  logic               have_prev_q;
  logic [QW-1:0]      qcnt_q;
  logic signed [16:0] dx_q, dy_q, dz_q, tx_q, ty_q, tz_q;
  logic signed [34:0] term_q, sx_q, sy_q, sz_q;
  logic [RAD_W-1:0]   norm_q;
  logic signed [26:0] offx_q, offy_q, offz_q;
  logic [1:0]         corner_q;
  logic [47:0]        out_q;

  logic               in_beat, out_beat;
  logic signed [15:0] bx, by, bz;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_neg, mul_done, sqrt_done, div_done;
  logic [MUL_P_W-1:0] prod;
  logic signed [34:0] pval, snew;
  logic [25:0]        omag;
  logic signed [26:0] oval;
  logic [ROOT_W-1:0]  root, den;
  logic [QUO_W-1:0]   quo;
  logic               use_b, neg;
  logic signed [15:0] px, py, pz;

  assign bx = s_axis_tdata[15:0];
  assign by = s_axis_tdata[31:16];
  assign bz = s_axis_tdata[47:32];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == ST_IDLE;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = state_q == ST_EMIT;
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = corner_q;
  assign m_axis_tlast  = corner_q == CORNER_B_MINUS;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (op_q)
      OP_DY_TZ: begin
        mul_a   = MUL_A_W'(abs17(dy_q));
        mul_b   = MUL_B_W'(abs17(tz_q));
        mul_neg = dy_q[16] ^ tz_q[16];
      end
      OP_DZ_TY: begin
        mul_a   = MUL_A_W'(abs17(dz_q));
        mul_b   = MUL_B_W'(abs17(ty_q));
        mul_neg = dz_q[16] ^ ty_q[16];
      end
      OP_DZ_TX: begin
        mul_a   = MUL_A_W'(abs17(dz_q));
        mul_b   = MUL_B_W'(abs17(tx_q));
        mul_neg = dz_q[16] ^ tx_q[16];
      end
      OP_DX_TZ: begin
        mul_a   = MUL_A_W'(abs17(dx_q));
        mul_b   = MUL_B_W'(abs17(tz_q));
        mul_neg = dx_q[16] ^ tz_q[16];
      end
      OP_DX_TY: begin
        mul_a   = MUL_A_W'(abs17(dx_q));
        mul_b   = MUL_B_W'(abs17(ty_q));
        mul_neg = dx_q[16] ^ ty_q[16];
      end
      OP_LAST_CROSS: begin
        mul_a   = MUL_A_W'(abs17(dy_q));
        mul_b   = MUL_B_W'(abs17(tx_q));
        mul_neg = dy_q[16] ^ tx_q[16];
      end
      OP_SQ_X: begin
        mul_a = abs35(sx_q); mul_b = MUL_B_W'(abs35(sx_q));
      end
      OP_SQ_Y: begin
        mul_a = abs35(sy_q); mul_b = MUL_B_W'(abs35(sy_q));
      end
      OP_LAST_SQ: begin
        mul_a = abs35(sz_q); mul_b = MUL_B_W'(abs35(sz_q));
      end
      OP_FIRST_OFF: begin
        mul_a = abs35(sx_q); mul_b = quo; mul_neg = sx_q[34];
      end
      OP_OFF_Y: begin
        mul_a = abs35(sy_q); mul_b = quo; mul_neg = sy_q[34];
      end
      OP_LAST_OFF: begin
        mul_a = abs35(sz_q); mul_b = quo; mul_neg = sz_q[34];
      end
      default: begin
        mul_a = '0;
      end
    endcase
    pval = mul_neg ? -$signed(prod[34:0]) : $signed(prod[34:0]);
    snew = term_q - pval;
    omag = prod[57:32];
    oval = mul_neg ? -$signed({1'b0, omag}) : $signed({1'b0, omag});
    den  = (root == '0) ? ROOT_W'(1) : root;
  end

  always_comb begin
    use_b = corner_q[1];
    neg   = corner_q[0];
    px    = use_b ? prev_x_q : a_x_q;
    py    = use_b ? prev_y_q : a_y_q;
    pz    = use_b ? prev_z_q : a_z_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat && !s_axis_tuser && have_prev_q && (qcnt_q < QW'(MAX_QUADS))) begin
          state_d = ST_MGO;
        end
      end
      ST_MGO: state_d = ST_MWT;
      ST_MWT: begin
        if (mul_done) begin
          if (op_q == OP_LAST_CROSS && sx_q == '0 && sy_q == '0 && snew == '0) begin
            state_d = ST_IDLE;
          end else if (op_q == OP_LAST_SQ) begin
            state_d = ST_SGO;
          end else if (op_q == OP_LAST_OFF) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_MGO;
          end
        end
      end
      ST_SGO: state_d = ST_SWT;
      ST_SWT: begin
        if (sqrt_done) begin
          state_d = ST_DGO;
        end
      end
      ST_DGO: state_d = ST_DWT;
      ST_DWT: begin
        if (div_done) begin
          state_d = ST_MGO;
        end
      end
      ST_LOAD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_beat) begin
          state_d = (corner_q == CORNER_B_MINUS) ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      corner_q    <= '0;
      eye_x_q     <= '0;
      eye_y_q     <= '0;
      eye_z_q     <= '0;
      hw_q        <= HALF_WIDTH_RST;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      have_prev_q <= 1'b0;
      qcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          REG_EYE_X:      eye_x_q <= cfg_data_i;
          REG_EYE_Y:      eye_y_q <= cfg_data_i;
          REG_EYE_Z:      eye_z_q <= cfg_data_i;
          REG_HALF_WIDTH: hw_q    <= cfg_data_i;
          default:        hw_q    <= hw_q;
        endcase
      end
      if (in_beat) begin
        prev_x_q    <= bx;
        prev_y_q    <= by;
        prev_z_q    <= bz;
        have_prev_q <= 1'b1;
        op_q        <= OP_DY_TZ;
        corner_q    <= '0;
        if (s_axis_tuser) begin
          qcnt_q <= '0;
        end
      end
      if (state_q == ST_MWT && mul_done) begin
        op_q <= op_q + 1'b1;
      end
      if (state_q == ST_DWT && div_done) begin
        op_q <= OP_FIRST_OFF;
      end
      if (out_beat) begin
        corner_q <= corner_q + 1'b1;
        if (corner_q == CORNER_B_MINUS) begin
          qcnt_q <= qcnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      a_x_q <= prev_x_q;
      a_y_q <= prev_y_q;
      a_z_q <= prev_z_q;
      dx_q  <= 17'(bx) - 17'(prev_x_q);
      dy_q  <= 17'(by) - 17'(prev_y_q);
      dz_q  <= 17'(bz) - 17'(prev_z_q);
      tx_q  <= 17'(eye_x_q) - 17'(prev_x_q);
      ty_q  <= 17'(eye_y_q) - 17'(prev_y_q);
      tz_q  <= 17'(eye_z_q) - 17'(prev_z_q);
    end
    if (state_q == ST_MWT && mul_done) begin
      case (op_q)
        OP_DY_TZ, OP_DZ_TX, OP_DX_TY: term_q <= pval;
        OP_DZ_TY:      sx_q   <= snew;
        OP_DX_TZ:      sy_q   <= snew;
        OP_LAST_CROSS: sz_q   <= snew;
        OP_SQ_X:       norm_q <= prod[RAD_W-1:0];
        OP_SQ_Y, OP_LAST_SQ: norm_q <= norm_q + prod[RAD_W-1:0];
        OP_FIRST_OFF:  offx_q <= oval;
        OP_OFF_Y:      offy_q <= oval;
        OP_LAST_OFF:   offz_q <= oval;
        default: term_q <= term_q;
      endcase
    end
    if (state_q == ST_LOAD) begin
      out_q <= {place(pz, offz_q, neg), place(py, offy_q, neg), place(px, offx_q, neg)};
    end
  end

  crb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_MGO),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  crb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_SGO),
    .rad_i   (norm_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  crb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DGO),
    .num_i   ({hw_q, 40'h0}),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );
endmodule

// ===== rtl/core/crb_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module crb_mul import crb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               done_o,
  output logic [MUL_P_W-1:0] prod_o
);
  localparam int unsigned CW = $clog2(MUL_A_W);

  logic               run_q, done_q;
  logic [CW-1:0]      cnt_q;
  logic [MUL_B_W-1:0] hi_q, b_q;
  logic [MUL_A_W-1:0] lo_q;
  logic [MUL_B_W:0]   add;

  assign add = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : {(MUL_B_W + 1){1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CW'(MUL_A_W - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MUL_A_W - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= a_i;
      b_q  <= b_i;
    end else if (run_q) begin
      hi_q <= add[MUL_B_W:1];
      lo_q <= {add[0], lo_q[MUL_A_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};
endmodule

// ===== rtl/core/crb_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module crb_sqrt import crb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);
  localparam int unsigned CW = $clog2(ROOT_W);

  logic              run_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W:0]   rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W+2:0] work, trial;
  logic              take;

  always_comb begin
    work  = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    trial = {1'b0, root_q, 2'b01};
    take  = work >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CW'(ROOT_W - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ROOT_W - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= take ? (ROOT_W+1)'(work - trial) : work[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== rtl/core/crb_div.sv =====
// Restoring divider, one quotient bit per cycle.
module crb_div import crb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QUO_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quo_o
);
  localparam int unsigned CW = $clog2(QUO_W);

  logic              run_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [QUO_W-1:0]  quo_q;
  logic [ROOT_W-1:0] den_q, rem_q;
  logic [ROOT_W:0]   work;
  logic              take;

  always_comb begin
    work = {rem_q, quo_q[QUO_W-1]};
    take = work >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CW'(QUO_W - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QUO_W - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= take ? ROOT_W'(work - {1'b0, den_q}) : work[ROOT_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/core/crb_checker.sv =====
// Port-level checker of the ribbon quad block and its bind to the top level.
`include "assert_macros.svh"

module crb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  `CRB_ASSERT(a_last_on_final, !m_axis_tvalid || (m_axis_tlast == (m_axis_tuser == 2'd3)), "tlast does not match the final corner")
  `CRB_ASSERT(a_no_input_while_out, !m_axis_tvalid || !s_axis_tready, "input ready while a corner beat is pending")
  `CRB_ASSERT_NEXT(a_no_out_after_in, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "corner beat right after a point beat")
  `CRB_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output beat changed")
endmodule

bind camera_facing_ribbon_quads crb_checker u_crb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the camera-facing ribbon quad extruder.
module tb;
  import crb_pkg::*;

  localparam int unsigned QuadLimit  = 64;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned QuadCycles = 600;
  localparam int unsigned HoldCycles = 3000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         corner;
    logic               last;
  } vertex_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = REG_EYE_X;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  camera_facing_ribbon_quads #(.MAX_QUADS(QuadLimit)) dut (.*);

  // Mirror of the block state and registers.
  logic signed [15:0] eye_x, eye_y, eye_z;
  logic [15:0]        half_width;
  point_t             prev_pt;
  logic               prev_valid;
  int unsigned        quads_in_path;

  vertex_t     corner_queue[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;
  logic        free_run = 1'b0;
  int unsigned mode_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering beats.
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      mode_left <= $urandom_range(20, 400);
      free_run <= ($urandom_range(0, 2) == 0);
    end else begin
      mode_left <= mode_left - 1;
    end
    m_axis_tready <= (hold_left == 0) && !hold_start &&
                     (free_run || ($urandom_range(0, 3) != 0));
  end

  function automatic logic signed [15:0] offset_corner(longint p, longint s,
                                                       longint unsigned q, bit neg);
    longint unsigned mag_s;
    logic [95:0]     prod;
    longint          off, sum, t;
    mag_s = (s < 0) ? longint'(-s) : longint'(s);
    prod = 96'(mag_s) * 96'(q);
    off = longint'(prod[95:32]);
    if (s < 0) off = -off;
    if (neg) off = -off;
    sum = p * 65536 + off;
    t = sum / 65536;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  // Expected corners of the quad that point b closes, if any.
  function automatic void predict_quad(logic start, point_t b);
    longint          ax, ay, az, dx, dy, dz, tx, ty, tz, sx, sy, sz;
    longint unsigned ux, uy, uz, len, q;
    logic [71:0]     norm;
    logic [35:0]     root, trial;
    vertex_t         v;
    point_t          a;
    a = prev_pt;
    prev_pt = b;
    if (start || !prev_valid) begin
      if (start) quads_in_path = 0;
      prev_valid = 1'b1;
      return;
    end
    if (quads_in_path >= QuadLimit) return;
    ax = a.x; ay = a.y; az = a.z;
    dx = longint'(b.x) - ax; dy = longint'(b.y) - ay; dz = longint'(b.z) - az;
    tx = longint'(eye_x) - ax; ty = longint'(eye_y) - ay; tz = longint'(eye_z) - az;
    sx = dy * tz - dz * ty;
    sy = dz * tx - dx * tz;
    sz = dx * ty - dy * tx;
    if (sx == 0 && sy == 0 && sz == 0) return;
    ux = (sx < 0) ? -sx : sx;
    uy = (sy < 0) ? -sy : sy;
    uz = (sz < 0) ? -sz : sz;
    norm = 72'(ux) * 72'(ux) + 72'(uy) * 72'(uy) + 72'(uz) * 72'(uz);
    root = '0;
    for (int bit_i = 35; bit_i >= 0; bit_i--) begin
      trial = root | (36'd1 << bit_i);
      if (72'(trial) * 72'(trial) <= norm) root = trial;
    end
    len = (root == 0) ? 64'd1 : 64'(root);
    q = (64'(half_width) << 40) / len;
    for (int k = 0; k < 4; k++) begin
      v.x = offset_corner((k < 2) ? ax : longint'(b.x), sx, q, k[0]);
      v.y = offset_corner((k < 2) ? ay : longint'(b.y), sy, q, k[0]);
      v.z = offset_corner((k < 2) ? az : longint'(b.z), sz, q, k[0]);
      v.corner = k[1:0];
      v.last = (k == 3);
      corner_queue.push_back(v);
    end
    quads_in_path++;
  endfunction

  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[15:0];
      got.y = m_axis_tdata[31:16];
      got.z = m_axis_tdata[47:32];
      got.corner = m_axis_tuser;
      got.last = m_axis_tlast;
      if (corner_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected corner beat, expected none, actual %p", $time, got);
      end else begin
        want = corner_queue.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.corner !== want.corner || got.last !== want.last) begin
          errors++;
          $display("%0t: corner mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  task automatic send_point(logic start, point_t p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= start;
    s_axis_tdata <= {p.z, p.y, p.x};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_quad(start, p);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (corner_queue.size() != 0) @(posedge clk_i);
    repeat (QuadCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      REG_EYE_X:      eye_x = data;
      REG_EYE_Y:      eye_y = data;
      REG_EYE_Z:      eye_z = data;
      REG_HALF_WIDTH: half_width = data;
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] ex, logic [15:0] ey, logic [15:0] ez,
                           logic [15:0] hw);
    write_reg(REG_EYE_X, ex);
    write_reg(REG_EYE_Y, ey);
    write_reg(REG_EYE_Z, ez);
    write_reg(REG_HALF_WIDTH, hw);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic point_t pt(int x, int y, int z);
    point_t p;
    p.x = x[15:0]; p.y = y[15:0]; p.z = z[15:0];
    return p;
  endfunction

  function automatic point_t any_point();
    return pt($urandom, $urandom, $urandom);
  endfunction

  // Mostly short steps from the previous point, sometimes anywhere at all.
  function automatic point_t next_point();
    int span;
    if ($urandom_range(0, 4) == 0) return any_point();
    span = ($urandom_range(0, 1) == 0) ? 40 : 3000;
    return pt(int'(prev_pt.x) + $urandom_range(0, 2 * span) - span,
              int'(prev_pt.y) + $urandom_range(0, 2 * span) - span,
              int'(prev_pt.z) + $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic test_default_width();
    send_point(1'b1, pt(0, 0, 10));
    send_point(1'b0, pt(10, 0, 10));
    send_point(1'b0, pt(10, 20, 5));
    send_point(1'b0, pt(-5, 7, -3));
    wait_idle();
  endtask

  task automatic test_first_point();
    send_point(1'b1, pt(-32768, -32768, -32768));
    send_point(1'b1, pt(32767, 32767, 32767));
    send_point(1'b0, pt(-32768, 32767, -32768));
    send_point(1'b1, pt(100, -200, 300));
    wait_idle();
  endtask

  task automatic test_zero_side();
    configure(16'd0, 16'd0, 16'd0, 16'd1536);
    send_point(1'b1, pt(1, 1, 1));
    send_point(1'b0, pt(2, 2, 2));
    send_point(1'b0, pt(2, 2, 2));
    send_point(1'b0, pt(-9, -9, -9));
    send_point(1'b0, pt(4, 5, 6));
    wait_idle();
  endtask

  task automatic test_saturation();
    configure(16'h8000, 16'h7fff, 16'h8000, 16'hffff);
    send_point(1'b1, pt(32767, -32768, 32767));
    send_point(1'b0, pt(-32768, 32767, -32768));
    send_point(1'b0, pt(32767, 32767, -32768));
    wait_idle();
    configure(16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
    send_point(1'b1, pt(-32768, 0, 32767));
    send_point(1'b0, pt(32767, -32768, 0));
    wait_idle();
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_point(1'b1, pt(0, 0, 1));
    send_point(1'b0, pt(1, 0, 1));
    wait_idle();
  endtask

  task automatic test_quad_limit();
    configure(16'd50, 16'hffce, 16'd7, 16'd900);
    send_point(1'b1, any_point());
    repeat (QuadLimit + 4) send_point(1'b0, next_point());
    send_point(1'b1, any_point());
    send_point(1'b0, next_point());
    wait_idle();
  endtask

  task automatic test_backpressure();
    configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    send_point(1'b1, any_point());
    repeat (10) send_point(1'b0, next_point());
    wait_idle();
  endtask

  task automatic test_random_paths();
    int unsigned sent;
    sent = 0;
    while (sent < 60) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: configure(16'h8000, 16'h8000, 16'h8000, 16'hffff);
          1: configure(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
          default: configure(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom_range(0, 4096)));
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        send_point(1'($urandom_range(0, 1)), any_point());
        sent++;
      end else begin
        send_point(1'b1, any_point());
        sent++;
        repeat ($urandom_range(2, 10)) begin
          send_point($urandom_range(0, 15) == 0, next_point());
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    eye_x = '0; eye_y = '0; eye_z = '0;
    half_width = HALF_WIDTH_RST;
    prev_pt = '0;
    prev_valid = 1'b0;
    quads_in_path = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_width();
    test_first_point();
    test_zero_side();
    test_saturation();
    test_quad_limit();
    test_backpressure();
    test_random_paths();
    if (errors == 0 && corner_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/crb_pkg.sv
rtl/core/crb_mul.sv
rtl/core/crb_sqrt.sv
rtl/core/crb_div.sv
rtl/core/camera_facing_ribbon_quads.sv
rtl/core/crb_checker.sv
sim/tb.sv
